// ----- src/wfc3d_pkg.sv -----
// Shared types, codes and constants of the 3D tile solver.
package wfc3d_pkg;

  localparam int unsigned DEF_MAX_TILES   = 16;
  localparam int unsigned DEF_MAX_WIDTH   = 64;
  localparam int unsigned DEF_MAX_HEIGHT  = 64;
  localparam int unsigned DEF_MAX_DEPTH   = 32;
  localparam int unsigned DEF_STACK_DEPTH = 8192;
  localparam int unsigned DEF_SOCKET_BITS = 8;

  localparam logic [31:0] RNG_ZERO_SEED = 32'h9E3779B9;

  // socket side read on the source tile / on the neighbour tile, per direction
  localparam int unsigned OWN_SIDE   [6] = '{0, 2, 1, 3, 4, 5};
  localparam int unsigned OTHER_SIDE [6] = '{2, 0, 3, 1, 5, 4};

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SOLVE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_SOLVED   = 2'd0,
    ST_FAILED   = 2'd1,
    ST_NO_TILES = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_GRID_DEPTH   = 3'd2,
    REG_TILE_COUNT   = 3'd3,
    REG_BASE_SEED    = 3'd4,
    REG_MAX_ATTEMPTS = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_N    = 3'd0,
    DIR_S    = 3'd1,
    DIR_E    = 3'd2,
    DIR_W    = 3'd3,
    DIR_UP   = 3'd4,
    DIR_DOWN = 3'd5
  } dir_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RESULT,
    S_RD_WH, S_RD_LIN, S_RD_MEM, S_RD_DONE,
    S_SV_WH, S_SV_TOT,
    S_CB_ROW, S_CB_ROWW, S_CB_COL, S_CB_COLW,
    S_AT_INIT, S_INIT, S_SCAN_RD, S_SCAN_EV,
    S_MOD_GO, S_MOD_WAIT, S_PICK, S_COLLAPSE,
    S_POP, S_POP_W, S_LIN, S_SRC_RD, S_SRC_EV,
    S_DIR, S_NB_RD, S_NB_EV, S_FAIL,
    S_COPY_RD, S_COPY_WR
  } core_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] tile_slot;
    logic [7:0] socket_north;
    logic [7:0] socket_east;
    logic [7:0] socket_south;
    logic [7:0] socket_west;
    logic [7:0] socket_up;
    logic [7:0] socket_down;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [4:0] cell_z;
  } item_t;

  typedef struct packed {
    logic [3:0]  cell_tile;
    logic [1:0]  status;
    logic [31:0] seed_used;
  } result_t;

  typedef struct packed {
    logic [6:0]  grid_width;
    logic [6:0]  grid_height;
    logic [5:0]  grid_depth;
    logic [4:0]  tile_count;
    logic [31:0] base_seed;
    logic [7:0]  max_attempts;
  } cfg_t;

endpackage

// ----- src/wfc3d_mod.sv -----
// Bit-serial remainder unit: dividend modulo a small divisor, one bit a cycle.
module wfc3d_mod import wfc3d_pkg::*; #(
  parameter int unsigned MAX_TILES = DEF_MAX_TILES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [31:0]                      dividend,
  input  logic [$clog2(MAX_TILES+1)-1:0]   divisor,
  output logic                             done,
  output logic [$clog2(MAX_TILES+1)-1:0]   rem
);

  localparam int unsigned CNTW = $clog2(MAX_TILES + 1);

  logic            busy;
  logic [4:0]      bit_cnt;
  logic [31:0]     dvd;
  logic [CNTW-1:0] dv;
  logic [CNTW:0]   trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      bit_cnt <= '0;
      dvd     <= dividend;
      dv      <= divisor;
      rem     <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dv}) begin
        rem <= CNTW'(trial - {1'b0, dv});
      end else begin
        rem <= trial[CNTW-1:0];
      end
      dvd     <= {dvd[30:0], 1'b0};
      bit_cnt <= bit_cnt + 5'd1;
      if (bit_cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- src/wfc3d_cfg.sv -----
// Configuration registers behind the APB-style port.
module wfc3d_cfg import wfc3d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width   <= 7'd8;
      cfg.grid_height  <= 7'd8;
      cfg.grid_depth   <= 6'd4;
      cfg.tile_count   <= 5'd0;
      cfg.base_seed    <= 32'd1;
      cfg.max_attempts <= 8'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_GRID_WIDTH:   cfg.grid_width   <= pwdata[6:0];
        REG_GRID_HEIGHT:  cfg.grid_height  <= pwdata[6:0];
        REG_GRID_DEPTH:   cfg.grid_depth   <= pwdata[5:0];
        REG_TILE_COUNT:   cfg.tile_count   <= pwdata[4:0];
        REG_BASE_SEED:    cfg.base_seed    <= pwdata;
        REG_MAX_ATTEMPTS: cfg.max_attempts <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_WIDTH:   prdata = {25'd0, cfg.grid_width};
      REG_GRID_HEIGHT:  prdata = {25'd0, cfg.grid_height};
      REG_GRID_DEPTH:   prdata = {26'd0, cfg.grid_depth};
      REG_TILE_COUNT:   prdata = {27'd0, cfg.tile_count};
      REG_BASE_SEED:    prdata = cfg.base_seed;
      REG_MAX_ATTEMPTS: prdata = {24'd0, cfg.max_attempts};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/wfc3d_core.sv -----
// Solver sequencer: tile, cell, stack and result memories around the remainder unit.
module wfc3d_core import wfc3d_pkg::*; #(
  parameter int unsigned MAX_TILES   = DEF_MAX_TILES,
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned SOCKET_BITS = DEF_SOCKET_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_ready,
  output logic    res_valid,
  input  logic    res_take,
  output result_t res
);

  localparam int unsigned TW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_TILES + 1);
  localparam int unsigned CPW   = (MAX_TILES > 1) ? $clog2(MAX_TILES * MAX_TILES) : 1;
  localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ZW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int unsigned LW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned TOTW  = $clog2(CELLS + 1);
  localparam int unsigned WHW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SAW   = $clog2(STACK_DEPTH);
  localparam int unsigned STW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW    = XW + YW + ZW;
  localparam int unsigned MEMW  = 1 + TW + MAX_TILES;
  localparam int unsigned SB    = SOCKET_BITS;
  localparam int unsigned SKW   = 6 * SOCKET_BITS;

  function automatic logic [CNTW-1:0] popcount(input logic [MAX_TILES-1:0] v);
    logic [CNTW-1:0] acc;
    acc = '0;
    for (int i = 0; i < MAX_TILES; i++) begin
      acc = acc + CNTW'(v[i]);
    end
    return acc;
  endfunction

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = (s == 32'd0) ? RNG_ZERO_SEED : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  core_state_t state, state_next;

  // memories
  logic [MEMW-1:0] wmem [CELLS];
  logic [TW-1:0]   cmem [CELLS];
  logic [EW-1:0]   smem [STACK_DEPTH];
  logic [SKW-1:0]  kmem [MAX_TILES];

  logic            w_we, s_we, k_we, c_we;
  logic [LW-1:0]   w_wa, w_ra, c_wa, c_ra;
  logic [MEMW-1:0] w_wd, wrd;
  logic [SAW-1:0]  s_wa, s_ra;
  logic [EW-1:0]   s_wd, srd;
  logic [TW-1:0]   k_wa, k_ra, c_wd, crd;
  logic [SKW-1:0]  k_wd, krd;

  // working registers
  item_t                item_q;
  logic                 in_rng;
  logic [WHW-1:0]       wh;
  logic [TOTW-1:0]      total, c;
  logic [XW-1:0]        sx, cx;
  logic [YW-1:0]        sy, cy;
  logic [ZW-1:0]        sz, cz;
  logic [LW-1:0]        best_lin, lin, nlin;
  logic [EW-1:0]        best_xyz, nxyz;
  logic [MAX_TILES-1:0] best_opt, src_opt;
  logic [CNTW-1:0]      best_cnt, k;
  logic                 best_found;
  logic [TW-1:0]        t, pick, ci, cj;
  logic [STW-1:0]       top;
  dir_t                 dir;
  logic [SKW-1:0]       row;
  logic [7:0]           attempt;
  logic [31:0]          used, rng;
  status_t              last_status;
  logic [31:0]          last_seed;
  logic [3:0]           res_tile;
  // per direction: row of source tile i, bit of neighbour tile j
  logic [MAX_TILES*MAX_TILES-1:0] compat [6];

  // combinational helpers
  logic [6:0]           dim_w, dim_h;
  logic [5:0]           dim_d;
  logic [CNTW-1:0]      n;
  logic [31:0]          base, tries_m1;
  logic [MAX_TILES-1:0] full, allowed, cell_opt, nopt;
  logic                 cell_col, changed, c_last, cand, inb;
  logic [TW-1:0]        cell_choice;
  logic [CNTW-1:0]      cell_cnt;
  logic [XW-1:0]        nx;
  logic [YW-1:0]        ny;
  logic [ZW-1:0]        nz;
  logic [LW-1:0]        nl;
  logic                 mod_start, mod_done;
  logic [CNTW-1:0]      mod_rem;

  assign dim_w = (cfg.grid_width == 7'd0) ? 7'd1 :
                 (32'(cfg.grid_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg.grid_width;
  assign dim_h = (cfg.grid_height == 7'd0) ? 7'd1 :
                 (32'(cfg.grid_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg.grid_height;
  assign dim_d = (cfg.grid_depth == 6'd0) ? 6'd1 :
                 (32'(cfg.grid_depth) > MAX_DEPTH) ? 6'(MAX_DEPTH) : cfg.grid_depth;
  assign n     = (32'(cfg.tile_count) > MAX_TILES) ? CNTW'(MAX_TILES) : CNTW'(cfg.tile_count);
  assign base  = (cfg.base_seed == 32'd0) ? 32'd1 : cfg.base_seed;
  assign tries_m1 = (cfg.max_attempts == 8'd0) ? 32'd0 : 32'(cfg.max_attempts) - 32'd1;

  assign cell_col    = wrd[MEMW-1];
  assign cell_choice = wrd[MAX_TILES +: TW];
  assign cell_opt    = wrd[MAX_TILES-1:0];
  assign cell_cnt    = popcount(cell_opt);
  assign nopt        = cell_opt & allowed;
  assign changed     = !cell_col && (nopt != cell_opt);
  assign c_last      = ((c + TOTW'(1)) == total);
  assign cand        = !cell_col && (!best_found || cell_cnt < best_cnt);

  always_comb begin
    for (int i = 0; i < MAX_TILES; i++) begin
      full[i] = (CNTW'(i) < n);
    end
  end

  always_comb begin
    allowed = '0;
    for (int i = 0; i < MAX_TILES; i++) begin
      if (src_opt[i]) begin
        allowed = allowed | compat[dir][i*MAX_TILES +: MAX_TILES];
      end
    end
  end

  always_comb begin
    nx  = cx;
    ny  = cy;
    nz  = cz;
    nl  = lin;
    inb = 1'b0;
    unique case (dir)
      DIR_N: begin
        inb = (32'(cy) + 32'd1) < 32'(dim_h);
        ny  = YW'(32'(cy) + 32'd1);
        nl  = LW'(32'(lin) + 32'(dim_w));
      end
      DIR_S: begin
        inb = (cy != '0);
        ny  = YW'(32'(cy) - 32'd1);
        nl  = LW'(32'(lin) - 32'(dim_w));
      end
      DIR_E: begin
        inb = (32'(cx) + 32'd1) < 32'(dim_w);
        nx  = XW'(32'(cx) + 32'd1);
        nl  = LW'(32'(lin) + 32'd1);
      end
      DIR_W: begin
        inb = (cx != '0);
        nx  = XW'(32'(cx) - 32'd1);
        nl  = LW'(32'(lin) - 32'd1);
      end
      DIR_UP: begin
        inb = (32'(cz) + 32'd1) < 32'(dim_d);
        nz  = ZW'(32'(cz) + 32'd1);
        nl  = LW'(32'(lin) + 32'(wh));
      end
      DIR_DOWN: begin
        inb = (cz != '0);
        nz  = ZW'(32'(cz) - 32'd1);
        nl  = LW'(32'(lin) - 32'(wh));
      end
      default: inb = 1'b0;
    endcase
  end

  wfc3d_mod #(
    .MAX_TILES (MAX_TILES)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (xorshift(rng)),
    .divisor  (best_cnt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    wrd <= wmem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_wa] <= c_wd;
    end
    crd <= cmem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    srd <= smem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      kmem[k_wa] <= k_wd;
    end
    krd <= kmem[k_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    mod_start  = 1'b0;
    w_we = 1'b0;
    w_wa = nlin;
    w_wd = {1'b0, cell_choice, nopt};
    w_ra = lin;
    s_we = 1'b0;
    s_wa = top[SAW-1:0];
    s_wd = nxyz;
    s_ra = SAW'(top - STW'(1));
    k_we = 1'b0;
    k_wa = TW'(item.tile_slot);
    k_wd = {SB'(item.socket_down), SB'(item.socket_up), SB'(item.socket_west),
            SB'(item.socket_south), SB'(item.socket_east), SB'(item.socket_north)};
    k_ra = ci;
    c_we = 1'b0;
    c_wa = c[LW-1:0];
    c_wd = '0;
    c_ra = lin;
    unique case (state)
      S_CLEAR: begin
        c_we = 1'b1;
        if ((c + TOTW'(1)) == TOTW'(CELLS)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (item.kind)
            KIND_LOAD: begin
              k_we       = (32'(item.tile_slot) < MAX_TILES);
              state_next = S_RESULT;
            end
            KIND_SOLVE: state_next = (n == '0) ? S_RESULT : S_SV_WH;
            KIND_READ:  state_next = S_RD_WH;
            default:    state_next = S_RESULT;
          endcase
        end
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      S_RD_WH:   state_next = S_RD_LIN;
      S_RD_LIN:  state_next = S_RD_MEM;
      S_RD_MEM:  state_next = S_RD_DONE;
      S_RD_DONE: state_next = S_RESULT;
      S_SV_WH:   state_next = S_SV_TOT;
      S_SV_TOT:  state_next = S_CB_ROW;
      S_CB_ROW:  state_next = S_CB_ROWW;
      S_CB_ROWW: state_next = S_CB_COL;
      S_CB_COL: begin
        k_ra       = cj;
        state_next = S_CB_COLW;
      end
      S_CB_COLW: begin
        if ((CNTW'(cj) + CNTW'(1)) != n) begin
          state_next = S_CB_COL;
        end else if ((CNTW'(ci) + CNTW'(1)) != n) begin
          state_next = S_CB_ROW;
        end else begin
          state_next = S_AT_INIT;
        end
      end
      S_AT_INIT: state_next = S_INIT;
      S_INIT: begin
        w_we = 1'b1;
        w_wa = c[LW-1:0];
        w_wd = {1'b0, {TW{1'b0}}, full};
        if (c_last) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        w_ra       = c[LW-1:0];
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (!cell_col && cell_cnt == '0) begin
          state_next = S_FAIL;
        end else if (!c_last) begin
          state_next = S_SCAN_RD;
        end else if (best_found || cand) begin
          state_next = S_MOD_GO;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_MOD_GO: begin
        mod_start  = 1'b1;
        state_next = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (mod_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (best_opt[t] && k == '0) begin
          state_next = S_COLLAPSE;
        end
      end
      S_COLLAPSE: begin
        w_we       = 1'b1;
        w_wa       = best_lin;
        w_wd       = {1'b1, pick, MAX_TILES'(1) << pick};
        s_we       = 1'b1;
        s_wa       = '0;
        s_wd       = best_xyz;
        state_next = S_POP;
      end
      S_POP:    state_next = (top == '0) ? S_SCAN_RD : S_POP_W;
      S_POP_W:  state_next = S_LIN;
      S_LIN:    state_next = S_SRC_RD;
      S_SRC_RD: state_next = S_SRC_EV;
      S_SRC_EV: state_next = S_DIR;
      S_DIR: begin
        if (inb) begin
          state_next = S_NB_RD;
        end else if (dir == DIR_DOWN) begin
          state_next = S_POP;
        end
      end
      S_NB_RD: begin
        w_ra       = nlin;
        state_next = S_NB_EV;
      end
      S_NB_EV: begin
        w_we = changed;
        if (changed && nopt == '0) begin
          state_next = S_FAIL;
        end else if (changed && top == STW'(STACK_DEPTH)) begin
          state_next = S_FAIL;
        end else begin
          s_we       = changed;
          state_next = (dir == DIR_DOWN) ? S_POP : S_DIR;
        end
      end
      S_FAIL: state_next = (32'(attempt) < tries_m1) ? S_AT_INIT : S_RESULT;
      S_COPY_RD: begin
        w_ra       = c[LW-1:0];
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        c_we       = 1'b1;
        c_wd       = cell_choice;
        state_next = c_last ? S_RESULT : S_COPY_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c           <= '0;
      top         <= '0;
      rng         <= 32'd1;
      last_status <= ST_FAILED;
      last_seed   <= 32'd0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          c <= c + TOTW'(1);
        end
        S_IDLE: begin
          if (item_valid) begin
            item_q   <= item;
            res_tile <= 4'd0;
            in_rng   <= (item.kind == KIND_READ) &&
                        (32'(item.cell_x) < 32'(dim_w)) &&
                        (32'(item.cell_y) < 32'(dim_h)) &&
                        (32'(item.cell_z) < 32'(dim_d));
            if (item.kind == KIND_SOLVE && n == '0) begin
              last_status <= ST_NO_TILES;
            end
          end
        end
        S_RD_WH, S_SV_WH: begin
          wh <= WHW'(32'(dim_w) * 32'(dim_h));
        end
        S_RD_LIN: begin
          lin <= LW'(32'(item_q.cell_z) * 32'(wh) + 32'(item_q.cell_y) * 32'(dim_w)
                     + 32'(item_q.cell_x));
        end
        S_RD_DONE: begin
          res_tile <= in_rng ? 4'(crd) : 4'd0;
        end
        S_SV_TOT: begin
          total   <= TOTW'(32'(wh) * 32'(dim_d));
          ci      <= '0;
          attempt <= 8'd0;
        end
        S_CB_ROWW: begin
          row <= krd;
          cj  <= '0;
        end
        S_CB_COLW: begin
          for (int dd = 0; dd < 6; dd++) begin
            compat[dd][CPW'(32'(ci) * MAX_TILES + 32'(cj))] <=
              (row[OWN_SIDE[dd]*SB +: SB] == krd[OTHER_SIDE[dd]*SB +: SB]);
          end
          cj <= cj + TW'(1);
          if ((CNTW'(cj) + CNTW'(1)) == n) begin
            ci <= ci + TW'(1);
          end
        end
        S_AT_INIT: begin
          used <= base + 32'(attempt);
          rng  <= ((base + 32'(attempt)) == 32'd0) ? 32'd1 : base + 32'(attempt);
          c    <= '0;
        end
        S_INIT: begin
          c <= c + TOTW'(1);
          if (c_last) begin
            c          <= '0;
            sx         <= '0;
            sy         <= '0;
            sz         <= '0;
            best_found <= 1'b0;
          end
        end
        S_SCAN_EV: begin
          if (cand) begin
            best_found <= 1'b1;
            best_cnt   <= cell_cnt;
            best_lin   <= c[LW-1:0];
            best_xyz   <= {sz, sy, sx};
            best_opt   <= cell_opt;
          end
          c <= c + TOTW'(1);
          if (32'(sx) + 32'd1 == 32'(dim_w)) begin
            sx <= '0;
            if (32'(sy) + 32'd1 == 32'(dim_h)) begin
              sy <= '0;
              sz <= ZW'(32'(sz) + 32'd1);
            end else begin
              sy <= YW'(32'(sy) + 32'd1);
            end
          end else begin
            sx <= XW'(32'(sx) + 32'd1);
          end
          if (c_last && !best_found && !cand) begin
            last_status <= ST_SOLVED;
            last_seed   <= used;
            c           <= '0;
          end
        end
        S_MOD_GO: begin
          rng <= xorshift(rng);
        end
        S_MOD_WAIT: begin
          k <= mod_rem;
          t <= '0;
        end
        S_PICK: begin
          if (best_opt[t]) begin
            k <= k - CNTW'(1);
          end
          pick <= t;
          t    <= t + TW'(1);
        end
        S_COLLAPSE: begin
          top <= STW'(1);
        end
        S_POP: begin
          if (top == '0) begin
            c          <= '0;
            sx         <= '0;
            sy         <= '0;
            sz         <= '0;
            best_found <= 1'b0;
          end else begin
            top <= top - STW'(1);
          end
        end
        S_POP_W: begin
          {cz, cy, cx} <= srd;
        end
        S_LIN: begin
          lin <= LW'(32'(cz) * 32'(wh) + 32'(cy) * 32'(dim_w) + 32'(cx));
        end
        S_SRC_EV: begin
          src_opt <= cell_opt;
          dir     <= DIR_N;
        end
        S_DIR: begin
          nlin <= nl;
          nxyz <= {nz, ny, nx};
          if (!inb && dir != DIR_DOWN) begin
            dir <= dir_t'(dir + 3'd1);
          end
        end
        S_NB_EV: begin
          if (changed && nopt != '0 && top != STW'(STACK_DEPTH)) begin
            top <= top + STW'(1);
          end
          if (dir != DIR_DOWN) begin
            dir <= dir_t'(dir + 3'd1);
          end
        end
        S_FAIL: begin
          if (32'(attempt) < tries_m1) begin
            attempt <= attempt + 8'd1;
          end else begin
            last_status <= ST_FAILED;
            last_seed   <= used;
          end
        end
        S_COPY_WR: begin
          c <= c + TOTW'(1);
        end
        default: ;
      endcase
    end
  end

  assign res.cell_tile = res_tile;
  assign res.status    = last_status;
  assign res.seed_used = last_seed;

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    top <= STW'(STACK_DEPTH))
    else $error("stack pointer past its depth");

  a_mod_divisor: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD_GO |-> best_cnt != '0)
    else $error("remainder started with a zero divisor");

  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> k < best_cnt)
    else $error("pick index beyond the option count");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && !res_take |=> state == S_RESULT)
    else $error("result dropped before it was taken");

endmodule

// ----- src/wfc_3d_tile_solver.sv -----
// Top level of the 3D tile solver: configuration port, solver core and result register.
//
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    item_t: load sockets, solve, read cell
//  rsp      out  rsp_valid/stall    result_t: tile, status, seed
//  apb      in   psel/penable       six configuration registers
//
// After reset the result store is cleared before the first request is accepted.
// Load writes a tile's sockets to the tile table, read fetches one result cell; solve
// builds the socket compatibility table, then per attempt resets all cell domains and,
// per collapse, scans every cell, runs the remainder unit, picks an option and updates
// the in-grid neighbours of each popped cell; a solved grid goes to the result store.
// A taken result frees the core; a stalled result register holds the core in wait.
module wfc_3d_tile_solver import wfc3d_pkg::*; #(
  parameter int unsigned MAX_TILES   = DEF_MAX_TILES,
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned SOCKET_BITS = DEF_SOCKET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  item_t       req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output result_t     rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    item_ready, res_valid, res_take;
  result_t res;

  wfc3d_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wfc3d_core #(
    .MAX_TILES   (MAX_TILES),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_DEPTH   (MAX_DEPTH),
    .STACK_DEPTH (STACK_DEPTH),
    .SOCKET_BITS (SOCKET_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (req_valid),
    .item       (req),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign req_stall = !item_ready;
  assign res_take  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule
